>>> sv/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Shared widths, register indexes, reset values and the configuration and beat
// types for the button debounce and long-press unit.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   // Field widths.
   localparam int TIME_W   = 32;
   localparam int THRESH_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = THRESH_W;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_MS   = 2'd0,
      CSR_LONG_PRESS_MS = 2'd1,
      CSR_ACTIVE_LOW    = 2'd2
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [THRESH_W-1:0] DEBOUNCE_MS_RESET   = 16'd30;
   localparam logic [THRESH_W-1:0] LONG_PRESS_MS_RESET = 16'd700;
   localparam logic                ACTIVE_LOW_RESET    = 1'b1;

   // Current configuration as seen by the state machine.
   typedef struct packed {
      logic [THRESH_W-1:0] debounce_ms;
      logic [THRESH_W-1:0] long_press_ms;
      logic                active_low;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic held;
      logic long_press_event;
      logic release_event;
      logic short_press_event;
   } result_type;

endpackage

>>> sv/bdlp_if.sv
// ----------------------------------------------------------------------------
// Button debounce channels
// Valid/ready channels for scan tick beats and result beats.
// ----------------------------------------------------------------------------

// Scan tick channel: raw pin level and millisecond time.
interface bdlp_req_if;
   logic                       valid;
   logic                       ready;
   logic                       raw_level;
   logic [bdlp_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, raw_level, now_ms, input ready);
   modport sink   (input valid, raw_level, now_ms, output ready);
endinterface

// Result channel: held flag and single-tick events.
interface bdlp_rsp_if;
   logic valid;
   logic ready;
   logic held;
   logic long_press_event;
   logic release_event;
   logic short_press_event;

   modport source (output valid, held, long_press_event, release_event,
                   short_press_event, input ready);
   modport sink   (input valid, held, long_press_event, release_event,
                   short_press_event, output ready);
endinterface

>>> sv/bdlp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button debounce configuration registers
// Holds the debounce time, the long-press time and the pin polarity, written
// through a plain indexed write port.
// ----------------------------------------------------------------------------
module bdlp_cfg_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bdlp_pkg::cfg_type                 cfg
);

   bdlp_pkg::cfg_type cfg_ff;
   bdlp_pkg::cfg_type cfg_in;

   // Decode the write; an index beyond the register list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (bdlp_pkg::csr_index_type'(csr_index))
            bdlp_pkg::CSR_DEBOUNCE_MS:   cfg_in.debounce_ms   = csr_wdata;
            bdlp_pkg::CSR_LONG_PRESS_MS: cfg_in.long_press_ms = csr_wdata;
            bdlp_pkg::CSR_ACTIVE_LOW:    cfg_in.active_low    = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= bdlp_pkg::DEBOUNCE_MS_RESET;
         cfg_ff.long_press_ms <= bdlp_pkg::LONG_PRESS_MS_RESET;
         cfg_ff.active_low    <= bdlp_pkg::ACTIVE_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/bdlp_fsm.sv
// ----------------------------------------------------------------------------
// Button debounce state machine
// Five-state press/release machine with its entry time and long-press flag.
// Works out the result for the tick in the input register and advances the
// state when that tick moves on.
// ----------------------------------------------------------------------------
module bdlp_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  bdlp_pkg::cfg_type            cfg,
   input  logic                         step_en,
   input  logic                         raw_level,
   input  logic [bdlp_pkg::TIME_W-1:0]  now_ms,
   output bdlp_pkg::result_type         result
);

   typedef enum logic [2:0] {
      ST_IDLE        = 3'd0,
      ST_DEB_PRESS   = 3'd1,
      ST_PRESSED     = 3'd2,
      ST_LONG        = 3'd3,
      ST_DEB_RELEASE = 3'd4
   } state_type;

   state_type                   state_ff, state_in;
   logic [bdlp_pkg::TIME_W-1:0] entry_time_ff, entry_time_in;
   logic                        long_seen_ff, long_seen_in;

   logic                        pressed;
   logic [bdlp_pkg::TIME_W-1:0] elapsed;
   logic                        debounce_done;
   logic                        long_done;
   logic                        ev_long, ev_release, ev_short;

   // Polarity, elapsed time modulo 2^32 and the two threshold compares.
   assign pressed       = raw_level ^ cfg.active_low;
   assign elapsed       = now_ms - entry_time_ff;
   assign debounce_done = elapsed >= {{(bdlp_pkg::TIME_W-bdlp_pkg::THRESH_W){1'b0}},
                                      cfg.debounce_ms};
   assign long_done     = elapsed >= {{(bdlp_pkg::TIME_W-bdlp_pkg::THRESH_W){1'b0}},
                                      cfg.long_press_ms};

   // Next state and events for this tick.
   always_comb begin
      state_in      = state_ff;
      entry_time_in = entry_time_ff;
      long_seen_in  = long_seen_ff;
      ev_long       = 1'b0;
      ev_release    = 1'b0;
      ev_short      = 1'b0;
      unique case (state_ff)
         ST_DEB_PRESS: begin
            if (!pressed) begin
               state_in = ST_IDLE;
            end else if (debounce_done) begin
               state_in      = ST_PRESSED;
               entry_time_in = now_ms;
               long_seen_in  = 1'b0;
            end
         end
         ST_PRESSED: begin
            if (!pressed) begin
               state_in      = ST_DEB_RELEASE;
               entry_time_in = now_ms;
            end else if (!long_seen_ff && long_done) begin
               state_in     = ST_LONG;
               long_seen_in = 1'b1;
               ev_long      = 1'b1;
            end
         end
         ST_LONG: begin
            if (!pressed) begin
               state_in      = ST_DEB_RELEASE;
               entry_time_in = now_ms;
            end
         end
         ST_DEB_RELEASE: begin
            // A bounce goes back to the held state; the entry time is kept.
            if (pressed) begin
               state_in = long_seen_ff ? ST_LONG : ST_PRESSED;
            end else if (debounce_done) begin
               state_in   = ST_IDLE;
               ev_release = 1'b1;
               ev_short   = !long_seen_ff;
            end
         end
         default: begin
            // Idle, and any unused code, behaves as idle.
            if (pressed) begin
               state_in      = ST_DEB_PRESS;
               entry_time_in = now_ms;
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Result reflects the state after this tick.
   always_comb begin
      result.held              = (state_in == ST_PRESSED) || (state_in == ST_LONG);
      result.long_press_event  = ev_long;
      result.release_event     = ev_release;
      result.short_press_event = ev_short;
   end

   // State registers advance only when the tick moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         entry_time_ff <= '0;
         long_seen_ff  <= 1'b0;
      end else if (step_en) begin
         state_ff      <= state_in;
         entry_time_ff <= entry_time_in;
         long_seen_ff  <= long_seen_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A short press is only ever reported together with a release.
   a_short_needs_release: assert property (@(posedge clock) disable iff (reset)
      result.short_press_event |-> result.release_event)
      else $error("short press without release");

   // A long press event leaves the button held.
   a_long_is_held: assert property (@(posedge clock) disable iff (reset)
      result.long_press_event |-> result.held)
      else $error("long press event while not held");

   // After a confirmed release the machine sits in idle.
   a_release_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.release_event) |=> (state_ff == ST_IDLE))
      else $error("release did not return to idle");

   // The long-press flag is set only by stepping a tick that fires the event.
   a_long_seen_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(long_seen_ff) |-> $past(step_en && ev_long))
      else $error("long press flag set without event");
`endif

endmodule

>>> sv/button_debounce_long_press_unit.sv
// ----------------------------------------------------------------------------
// Button debounce and long-press unit
// Turns scan ticks (raw pin level and millisecond time) into a debounced held
// flag and single-tick long press, release and short press events.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Contents                                   Handshake
//   req_ch    in    raw_level, now_ms                          valid/ready
//   rsp_ch    out   held, long_press_event, release_event,     valid/ready
//                   short_press_event
//   csr_*     in    csr_index, csr_wdata                       csr_we, no wait
//
// One tick is accepted per cycle while rsp_ch does not stall; each gives one
// result beat through the input register, then the result register. The state
// machine step is combinational. Reset is synchronous and returns the machine
// to idle and the registers to their defaults. A stalled result beat holds both
// stages; while both are full, ready on req_ch follows rsp_ch.ready.
//
module button_debounce_long_press_unit (
   input  logic                              clock,
   input  logic                              reset,
   bdlp_req_if.sink                          req_ch,
   bdlp_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bdlp_pkg::cfg_type           cfg;
   bdlp_pkg::result_type        result;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_level_ff;
   logic [bdlp_pkg::TIME_W-1:0] s1_now_ms_ff;
   logic                        out_valid_ff, out_valid_in;
   bdlp_pkg::result_type        out_ff;

   logic                        s1_go;
   logic                        step_en;
   logic                        req_fire;

   // Configuration registers.
   bdlp_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The input stage moves on whenever the result register is free or drains.
   assign s1_go        = !out_valid_ff || rsp_ch.ready;
   assign step_en      = s1_valid_ff && s1_go;
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // State machine step on the registered tick.
   bdlp_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (step_en),
      .raw_level (s1_level_ff),
      .now_ms    (s1_now_ms_ff),
      .result    (result)
   );

   // Valid flags of the two stages.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
      end
      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_level_ff  <= req_ch.raw_level;
         s1_now_ms_ff <= req_ch.now_ms;
      end
      if (step_en) begin
         out_ff <= result;
      end
   end

   // Result beat.
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.held              = out_ff.held;
   assign rsp_ch.long_press_event  = out_ff.long_press_event;
   assign rsp_ch.release_event     = out_ff.release_event;
   assign rsp_ch.short_press_event = out_ff.short_press_event;

`ifndef NO_ASSERTIONS
   // A tick held in the input stage keeps its payload until it steps.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_now_ms_ff)
                                   && $stable(s1_level_ff)))
      else $error("input stage lost a waiting tick");

   // Every stepped tick appears as a result beat in the next cycle.
   a_step_gives_beat: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("stepped tick gave no result beat");

   // A full result register that is not taken is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |-> !step_en)
      else $error("result beat overwritten");
`endif

endmodule

>>> tb/tb_button_debounce_long_press_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce and long-press unit testbench
// Streams scan ticks into the unit, tracks the expected held flag and events
// with a cycle-free copy of the button state machine, and checks every result
// beat in order. Runs a directed sequence at the reset settings, then random
// press gestures and noise ticks under several threshold and polarity settings
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_unit;

   // States of the expected button behaviour.
   typedef enum logic [2:0] {
      BTN_IDLE,
      BTN_DEB_PRESS,
      BTN_PRESSED,
      BTN_LONG,
      BTN_DEB_RELEASE
   } btn_state_type;

   // One scan tick as queued for the driver.
   typedef struct packed {
      logic                        raw_level;
      logic [bdlp_pkg::TIME_W-1:0] now_ms;
   } scan_tick_type;

   localparam int HOLD_OFF_CYCLES = 300;

   logic clock;
   logic reset;
   logic                            csr_we;
   logic [bdlp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bdlp_pkg::CSR_DATA_W-1:0] csr_wdata;

   bdlp_req_if req_ch ();
   bdlp_rsp_if rsp_ch ();

   button_debounce_long_press_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Ticks waiting to be sent and results waiting to be seen.
   scan_tick_type           pending_ticks[$];
   bdlp_pkg::result_type    expected_results[$];
   scan_tick_type           next_tick;
   bdlp_pkg::result_type    want_beat;
   bdlp_pkg::result_type    got_beat;

   // Expected state of the button and the settings it runs under.
   bdlp_pkg::cfg_type           btn_cfg;
   btn_state_type               btn_state;
   logic [bdlp_pkg::TIME_W-1:0] btn_entry_ms;
   logic                        btn_long_seen;

   logic [bdlp_pkg::TIME_W-1:0] scan_ms;
   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  pressure_go;
   bit  hold_off;
   int  ticks_queued;
   int  results_seen;
   int  error_count;
   int  long_count;
   int  release_count;
   int  short_count;
   int  phases_run;

   always #2 clock = ~clock;

   // Advance the expected button state by one tick and return its result.
   function automatic bdlp_pkg::result_type debounce_step(
      input logic level, input logic [bdlp_pkg::TIME_W-1:0] now);
      bdlp_pkg::result_type        r;
      logic                        pressed;
      logic [bdlp_pkg::TIME_W-1:0] elapsed;
      r       = '0;
      pressed = btn_cfg.active_low ? !level : level;
      elapsed = now - btn_entry_ms;
      case (btn_state)
         BTN_DEB_PRESS: begin
            if (!pressed) begin
               btn_state = BTN_IDLE;
            end else if (elapsed >= {16'd0, btn_cfg.debounce_ms}) begin
               btn_state     = BTN_PRESSED;
               btn_entry_ms  = now;
               btn_long_seen = 1'b0;
            end
         end
         BTN_PRESSED: begin
            if (!pressed) begin
               btn_state    = BTN_DEB_RELEASE;
               btn_entry_ms = now;
            end else if (!btn_long_seen && elapsed >= {16'd0, btn_cfg.long_press_ms}) begin
               btn_long_seen      = 1'b1;
               btn_state          = BTN_LONG;
               r.long_press_event = 1'b1;
            end
         end
         BTN_LONG: begin
            if (!pressed) begin
               btn_state    = BTN_DEB_RELEASE;
               btn_entry_ms = now;
            end
         end
         BTN_DEB_RELEASE: begin
            if (pressed) begin
               // A bounce on release falls back to the held state; the entry
               // time stays where the release began.
               btn_state = btn_long_seen ? BTN_LONG : BTN_PRESSED;
            end else if (elapsed >= {16'd0, btn_cfg.debounce_ms}) begin
               btn_state           = BTN_IDLE;
               r.release_event     = 1'b1;
               r.short_press_event = !btn_long_seen;
            end
         end
         default: begin
            if (pressed) begin
               btn_state    = BTN_DEB_PRESS;
               btn_entry_ms = now;
            end else begin
               btn_state = BTN_IDLE;
            end
         end
      endcase
      r.held = (btn_state == BTN_PRESSED) || (btn_state == BTN_LONG);
      return r;
   endfunction

   // Time step scale, so that gestures cross the thresholds in a few ticks.
   function automatic int unsigned time_unit();
      return (int'(btn_cfg.debounce_ms) + int'(btn_cfg.long_press_ms)) / 6 + 1;
   endfunction

   task automatic queue_tick(input logic level, input logic [bdlp_pkg::TIME_W-1:0] now);
      scan_ms = now;
      pending_ticks.push_back('{level, now});
      ticks_queued++;
   endtask

   task automatic advance_tick(input logic level);
      queue_tick(level, scan_ms + $urandom_range(time_unit()));
   endtask

   // Random level at a random or nearby time.
   task automatic queue_noise();
      if ($urandom_range(3) == 0) begin
         queue_tick(1'($urandom_range(1)), $urandom);
      end else begin
         advance_tick(1'($urandom_range(1)));
      end
   endtask

   // A press gesture: optional time jump, rest, optional press bounce, hold with
   // the odd release glitch, then release.
   task automatic queue_gesture();
      logic on;
      on = btn_cfg.active_low ? 1'b0 : 1'b1;
      if ($urandom_range(9) == 0) begin
         scan_ms = $urandom;
      end else if ($urandom_range(19) == 0) begin
         scan_ms = 32'hFFFF_FFFF - $urandom_range(time_unit() * 4);
      end
      repeat ($urandom_range(2)) advance_tick(!on);
      if ($urandom_range(2) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            advance_tick(on);
            advance_tick(!on);
         end
      end
      repeat ($urandom_range(1, 20)) advance_tick(($urandom_range(9) == 0) ? !on : on);
      repeat ($urandom_range(1, 10)) advance_tick(!on);
   endtask

   task automatic write_csr(input bdlp_pkg::csr_index_type idx,
                            input logic [bdlp_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         bdlp_pkg::CSR_DEBOUNCE_MS:   btn_cfg.debounce_ms   = data;
         bdlp_pkg::CSR_LONG_PRESS_MS: btn_cfg.long_press_ms = data;
         bdlp_pkg::CSR_ACTIVE_LOW:    btn_cfg.active_low    = data[0];
         default: ;
      endcase
   endtask

   // Wait until every queued tick has produced its result beat.
   task automatic wait_drained();
      while (results_seen != ticks_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [bdlp_pkg::CSR_DATA_W-1:0] deb,
                            input logic [bdlp_pkg::CSR_DATA_W-1:0] lng,
                            input logic [bdlp_pkg::CSR_DATA_W-1:0] polarity, input int idle,
                            input int stall, input int n, input bit squeeze);
      int target;
      wait_drained();
      write_csr(bdlp_pkg::CSR_DEBOUNCE_MS, deb);
      write_csr(bdlp_pkg::CSR_LONG_PRESS_MS, lng);
      write_csr(bdlp_pkg::CSR_ACTIVE_LOW, polarity);
      @(posedge clock);
      csr_we <= 1'b0;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      target = ticks_queued + n;
      while (ticks_queued < target) begin
         if ($urandom_range(99) < 15) begin
            queue_noise();
         end else begin
            queue_gesture();
         end
      end
      if (squeeze) pressure_go = 1'b1;
      phases_run++;
   endtask

   // Driver: offers queued ticks and predicts each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(debounce_step(req_ch.raw_level, req_ch.now_ms));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_tick = pending_ticks.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.raw_level <= next_tick.raw_level;
               req_ch.now_ms    <= next_tick.now_ms;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            got_beat = '{rsp_ch.held, rsp_ch.long_press_event, rsp_ch.release_event,
                         rsp_ch.short_press_event};
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with no tick outstanding, expected none, got %b",
                        $time, got_beat);
               error_count++;
            end else begin
               want_beat = expected_results.pop_front();
               if (got_beat.held !== want_beat.held) begin
                  $display("%0t: held mismatch, expected %b, got %b",
                           $time, want_beat.held, got_beat.held);
                  error_count++;
               end
               if (got_beat.long_press_event !== want_beat.long_press_event) begin
                  $display("%0t: long_press_event mismatch, expected %b, got %b",
                           $time, want_beat.long_press_event, got_beat.long_press_event);
                  error_count++;
               end
               if (got_beat.release_event !== want_beat.release_event) begin
                  $display("%0t: release_event mismatch, expected %b, got %b",
                           $time, want_beat.release_event, got_beat.release_event);
                  error_count++;
               end
               if (got_beat.short_press_event !== want_beat.short_press_event) begin
                  $display("%0t: short_press_event mismatch, expected %b, got %b",
                           $time, want_beat.short_press_event, got_beat.short_press_event);
                  error_count++;
               end
               long_count    += want_beat.long_press_event;
               release_count += want_beat.release_event;
               short_count   += want_beat.short_press_event;
            end
         end
         rsp_ch.ready <= !hold_off && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off so that the unit fills and stalls its input.
   initial begin
      hold_off = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus and phase sequencing.
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = bdlp_pkg::CSR_DEBOUNCE_MS;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.raw_level = 1'b1;
      req_ch.now_ms    = '0;
      rsp_ch.ready     = 1'b0;
      btn_cfg          = '{bdlp_pkg::DEBOUNCE_MS_RESET, bdlp_pkg::LONG_PRESS_MS_RESET,
                           bdlp_pkg::ACTIVE_LOW_RESET};
      btn_state        = BTN_IDLE;
      btn_entry_ms     = '0;
      btn_long_seen    = 1'b0;
      scan_ms          = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      pressure_go      = 1'b0;
      ticks_queued     = 0;
      results_seen     = 0;
      error_count      = 0;
      long_count       = 0;
      release_count    = 0;
      short_count      = 0;
      phases_run       = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed run at the reset settings: 30 ms debounce, 700 ms long press,
      // low level pressed.
      queue_tick(1'b1, 32'd0);
      queue_tick(1'b0, 32'd100);           // press begins
      queue_tick(1'b1, 32'd105);           // press bounce, back to idle
      queue_tick(1'b0, 32'd110);
      queue_tick(1'b0, 32'd139);           // one short of the debounce time
      queue_tick(1'b0, 32'd140);           // press confirmed exactly on time
      queue_tick(1'b0, 32'd839);
      queue_tick(1'b0, 32'd840);           // long press fires
      queue_tick(1'b1, 32'd850);
      queue_tick(1'b0, 32'd860);           // release bounce returns to long press
      queue_tick(1'b1, 32'd870);
      queue_tick(1'b1, 32'd900);           // release, no short press
      queue_tick(1'b0, 32'd1000);
      queue_tick(1'b0, 32'd1030);
      queue_tick(1'b1, 32'd1040);
      queue_tick(1'b0, 32'd1045);          // release bounce back to pressed
      queue_tick(1'b0, 32'd1740);          // long timer counts from release start
      queue_tick(1'b1, 32'd1750);
      queue_tick(1'b1, 32'd1780);
      queue_tick(1'b0, 32'hFFFF_FFF0);     // press across the time wrap
      queue_tick(1'b0, 32'h0000_000E);
      queue_tick(1'b1, 32'h0000_0010);
      queue_tick(1'b1, 32'h0000_0040);     // release with short press
      queue_tick(1'b1, 32'hFFFF_FFFF);

      // Random gestures under changing settings and idling.
      run_phase(16'd5, 16'd40, 16'd0, 0, 0, 100, 1'b0);
      run_phase(16'd0, 16'd0, 16'd1, 49, 0, 100, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'd0, 0, 49, 100, 1'b0);
      run_phase(bdlp_pkg::CSR_DATA_W'($urandom_range(60)),
                bdlp_pkg::CSR_DATA_W'($urandom_range(400)),
                bdlp_pkg::CSR_DATA_W'({$urandom_range(32767), 1'b1}),
                24, 24, 100, 1'b0);
      run_phase(16'd10, 16'd80, 16'd1, 0, 0, 100, 1'b1);
      run_phase(bdlp_pkg::CSR_DATA_W'($urandom), bdlp_pkg::CSR_DATA_W'($urandom),
                bdlp_pkg::CSR_DATA_W'($urandom), 24, 24, 100, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived, expected %0d more beats, got none",
                  $time, expected_results.size(), expected_results.size());
         error_count++;
      end

      $display("Sent %0d scan ticks over %0d settings, with idling and a %0d-cycle hold-off.",
               ticks_queued, phases_run, HOLD_OFF_CYCLES);
      $display("Checked %0d result beats: %0d long presses, %0d releases, %0d short presses.",
               results_seen, long_count, release_count, short_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> button_debounce_long_press_unit.f
sv/bdlp_pkg.sv
sv/bdlp_if.sv
sv/bdlp_cfg_regs.sv
sv/bdlp_fsm.sv
sv/button_debounce_long_press_unit.sv
tb/tb_button_debounce_long_press_unit.sv
